// ----- design/tpsv_pkg.sv -----
// Package for the text package stream verifier: parser mode codes, keyword
// tables, hash constants and the result struct. No dependencies.
package tpsv_pkg;

  localparam logic [2:0] MODE_HEADER    = 3'd0;
  localparam logic [2:0] MODE_MAIN      = 3'd1;
  localparam logic [2:0] MODE_BODY_WAIT = 3'd2;
  localparam logic [2:0] MODE_BODY      = 3'd3;
  localparam logic [2:0] MODE_DONE      = 3'd4;
  localparam logic [2:0] MODE_BAD       = 3'd5;

  localparam int KW_HDR  = 0;
  localparam int KW_END  = 1;
  localparam int KW_ENDF = 2;
  localparam int KW_FILE = 3;
  localparam logic [3:0] KW_ALL = 4'hF;

  localparam logic [3:0] POS_MAX = 4'd15;

  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_SP  = 8'd32;
  localparam logic [7:0] CHAR_TAB = 8'd9;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] file_count;
    logic [31:0] body_bytes;
    logic [15:0] error_count;
    logic        end_missing;
    logic [31:0] hash;
  } tpsv_res_t;

  // header word, seven characters
  function automatic logic [7:0] hdr_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h4C;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h41;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h4B;
      3'd5:    c = 8'h20;
      3'd6:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "ENDFILE"; its first three characters also form "END"
  function automatic logic [7:0] endf_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h4E;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h46;
      3'd4:    c = 8'h49;
      3'd5:    c = 8'h4C;
      3'd6:    c = 8'h45;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "FILE"
  function automatic logic [7:0] file_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h46;
      2'd1:    c = 8'h49;
      2'd2:    c = 8'h4C;
      default: c = 8'h45;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SP) || (b == CHAR_TAB);
  endfunction

endpackage

// ----- design/tpsv_parse.sv -----
// Byte parser for the stream verifier: line tracking, keyword match, counters
// and FNV-1a hash. State advances on step_en; result is combinational.
// Depends on tpsv_pkg.
module tpsv_parse
  import tpsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  output tpsv_res_t  res
);

  logic [2:0]  mode_r, mode_nxt;
  logic        als_r, als_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [3:0]  kwf_r, kwf_nxt;
  logic        name_r, name_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] bs_r, bs_nxt;
  logic [31:0] lls_r, lls_nxt;
  logic [15:0] files_r, files_nxt;
  logic [31:0] total_r, total_nxt;
  logic [15:0] errs_r, errs_nxt;
  logic        end_r, end_nxt;
  logic [31:0] hash_r, hash_nxt;

  logic        sep;
  logic [2:0]  mode1, mode2, mode3;
  logic [3:0]  pos0, posm, lpos;
  logic [3:0]  kwf0, kwm, lkwf;
  logic        nm0, nmm, lname;
  logic [31:0] bs1, lls1;
  logic        ld;
  logic        errs_set;
  logic [1:0]  err_inc;
  logic        file_inc;
  logic        end1;
  logic        add_en;
  logic        valid;
  logic [15:0] files_a;
  logic [15:0] errs_base;
  logic [16:0] errs_sum;
  logic [15:0] errs_a;
  logic [31:0] diff;
  logic [32:0] bsum;
  logic [31:0] total_a;
  logic [31:0] prod;

  assign prod = (hash_r ^ {24'd0, byte_in}) * FNV_PRIME;

  always_comb begin
    sep = (byte_in == CHAR_CR) || (byte_in == CHAR_LF);

    mode1 = mode_r;
    pos0  = pos_r;
    kwf0  = kwf_r;
    nm0   = name_r;
    bs1   = bs_r;
    lls1  = lls_r;
    if (!sep && als_r) begin
      pos0 = 4'd0;
      kwf0 = KW_ALL;
      nm0  = 1'b0;
      lls1 = off_r;
      if (mode_r == MODE_BODY_WAIT) begin
        bs1   = off_r;
        mode1 = MODE_BODY;
      end
    end

    kwm = kwf0;
    nmm = nm0;
    if (!(pos0 < 4'd7 && hdr_char(pos0[2:0]) == byte_in)) kwm[KW_HDR] = 1'b0;
    if (!(pos0 < 4'd3 && endf_char(pos0[2:0]) == byte_in)) kwm[KW_END] = 1'b0;
    if (!(pos0 < 4'd7 && endf_char(pos0[2:0]) == byte_in)) kwm[KW_ENDF] = 1'b0;
    if (pos0 < 4'd4) begin
      if (file_char(pos0[1:0]) != byte_in) kwm[KW_FILE] = 1'b0;
    end else if (pos0 == 4'd4) begin
      if (!is_blank(byte_in)) kwm[KW_FILE] = 1'b0;
    end else if (!is_blank(byte_in)) begin
      nmm = 1'b1;
    end
    posm = (pos0 < POS_MAX) ? pos0 + 4'd1 : POS_MAX;

    lpos  = sep ? pos_r  : posm;
    lkwf  = sep ? kwf_r  : kwm;
    lname = sep ? name_r : nmm;
    ld    = sep ? !als_r : last_byte;

    mode2    = mode1;
    errs_set = 1'b0;
    err_inc  = 2'd0;
    file_inc = 1'b0;
    end1     = end_r;
    add_en   = 1'b0;
    if (ld) begin
      case (mode1)
        MODE_HEADER: begin
          if (lkwf[KW_HDR] && lpos == 4'd7) begin
            mode2 = MODE_MAIN;
          end else begin
            errs_set = 1'b1;
            mode2    = MODE_BAD;
          end
        end
        MODE_MAIN: begin
          if (lkwf[KW_END] && lpos == 4'd3) begin
            end1  = 1'b1;
            mode2 = MODE_DONE;
          end else if (lkwf[KW_FILE] && lpos >= 4'd4) begin
            file_inc = 1'b1;
            if (!lname) err_inc = err_inc + 2'd1;
            mode2 = MODE_BODY_WAIT;
          end
        end
        MODE_BODY: begin
          if (lkwf[KW_ENDF] && lpos == 4'd7) begin
            add_en = 1'b1;
            mode2  = MODE_MAIN;
          end
        end
        default: begin
        end
      endcase
    end

    mode3 = mode2;
    if (last_byte) begin
      case (mode2)
        MODE_HEADER: begin
          errs_set = 1'b1;
          mode3    = MODE_BAD;
        end
        MODE_BODY_WAIT: err_inc = err_inc + 2'd1;
        MODE_BODY: begin
          err_inc = err_inc + 2'd1;
          add_en  = 1'b1;
        end
        default: begin
        end
      endcase
    end

    files_a = (file_inc && files_r != 16'hFFFF) ? files_r + 16'd1 : files_r;
    valid   = mode3 != MODE_BAD;
    if (last_byte && valid && files_a == 16'd0) err_inc = err_inc + 2'd1;

    errs_base = errs_set ? 16'd1 : errs_r;
    errs_sum  = {1'b0, errs_base} + {15'd0, err_inc};
    errs_a    = errs_sum[16] ? 16'hFFFF : errs_sum[15:0];

    diff    = lls1 - bs1;
    bsum    = {1'b0, total_r} + {1'b0, diff};
    total_a = add_en ? (bsum[32] ? 32'hFFFF_FFFF : bsum[31:0]) : total_r;

    res.valid_res   = valid;
    res.file_count  = files_a;
    res.body_bytes  = total_a;
    res.error_count = errs_a;
    res.end_missing = !end1;
    res.hash        = prod;

    if (last_byte) begin
      mode_nxt  = MODE_HEADER;
      als_nxt   = 1'b1;
      pos_nxt   = 4'd0;
      kwf_nxt   = KW_ALL;
      name_nxt  = 1'b0;
      off_nxt   = 32'd0;
      bs_nxt    = 32'd0;
      lls_nxt   = 32'd0;
      files_nxt = 16'd0;
      total_nxt = 32'd0;
      errs_nxt  = 16'd0;
      end_nxt   = 1'b0;
      hash_nxt  = FNV_BASIS;
    end else begin
      mode_nxt  = mode2;
      als_nxt   = sep ? 1'b1 : 1'b0;
      pos_nxt   = lpos;
      kwf_nxt   = lkwf;
      name_nxt  = lname;
      off_nxt   = off_r + 32'd1;
      bs_nxt    = bs1;
      lls_nxt   = lls1;
      files_nxt = files_a;
      total_nxt = total_a;
      errs_nxt  = errs_a;
      end_nxt   = end1;
      hash_nxt  = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HEADER;
      als_r   <= 1'b1;
      pos_r   <= 4'd0;
      kwf_r   <= KW_ALL;
      name_r  <= 1'b0;
      off_r   <= 32'd0;
      bs_r    <= 32'd0;
      lls_r   <= 32'd0;
      files_r <= 16'd0;
      total_r <= 32'd0;
      errs_r  <= 16'd0;
      end_r   <= 1'b0;
      hash_r  <= FNV_BASIS;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      als_r   <= als_nxt;
      pos_r   <= pos_nxt;
      kwf_r   <= kwf_nxt;
      name_r  <= name_nxt;
      off_r   <= off_nxt;
      bs_r    <= bs_nxt;
      lls_r   <= lls_nxt;
      files_r <= files_nxt;
      total_r <= total_nxt;
      errs_r  <= errs_nxt;
      end_r   <= end_nxt;
      hash_r  <= hash_nxt;
    end
  end

endmodule

// ----- design/text_package_stream_verifier_top.sv -----
// Text package stream verifier, top level: input handshake, parser and the
// registered result stage. out_valid rises in the cycle after the byte marked
// last is taken. Throughput: one byte per cycle; bytes stall only while a
// result waits unread. Synchronous active-low reset returns the parser to the
// header state and clears out_valid, with no clearing pass; the result
// register itself is not reset. Depends on tpsv_pkg, tpsv_parse.
module text_package_stream_verifier_top
  import tpsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [15:0] out_file_count,
  output logic [31:0] out_body_bytes,
  output logic [15:0] out_error_count,
  output logic        out_end_missing,
  output logic [31:0] out_hash
);

  logic      step_en;
  logic      out_valid_r, out_valid_nxt;
  tpsv_res_t res;
  tpsv_res_t res_r;

  assign in_stall = out_valid_r && out_stall;
  assign step_en  = in_valid && !in_stall;

  tpsv_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .byte_in   (in_byte_in),
    .last_byte (in_last_byte),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && in_last_byte) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_r.valid_res;
  assign out_file_count  = res_r.file_count;
  assign out_body_bytes  = res_r.body_bytes;
  assign out_error_count = res_r.error_count;
  assign out_end_missing = res_r.end_missing;
  assign out_hash        = res_r.hash;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> out_valid)
    else $error("result missing after last item");

  a_taken_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !(in_valid && !in_stall && in_last_byte)) |=> !out_valid)
    else $error("result repeated");

  a_bad_header_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (out_end_missing && out_file_count == 16'd0 && out_body_bytes == 32'd0
       && out_error_count == 16'd1))
    else $error("bad header result inconsistent");

  a_no_files_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_file_count == 16'd0) |-> (out_error_count != 16'd0))
    else $error("no files but no error");

endmodule

// ----- sim/tpsv_scan_pkg.sv -----
// Scoreboard for the text package stream verifier: rebuilds the per-package
// report from the accepted bytes and checks the reports that come out.
// Depends on tpsv_pkg for mode codes, keyword bit indexes, constants and tpsv_res_t.
package tpsv_scan_pkg;
  import tpsv_pkg::*;

  // keyword bytes, first character in the top byte
  localparam logic [55:0] HDR_WORD  = 56'h4C_50_41_43_4B_20_31;
  localparam logic [55:0] ENDF_WORD = 56'h45_4E_44_46_49_4C_45;
  localparam logic [31:0] FILE_WORD = 32'h46_49_4C_45;

  class pkg_scan_board;
    logic [2:0]  mode;
    logic        at_start;
    logic [3:0]  pos;
    logic [3:0]  kw_flags;
    logic        name_seen;
    logic [31:0] offset;
    logic [31:0] body_start;
    logic [31:0] line_start;
    logic [15:0] files;
    logic [31:0] body_total;
    logic [15:0] errors;
    logic        end_seen;
    logic [31:0] hash;
    tpsv_res_t   pending_reports[$];
    int          reports_seen;
    int          good_headers;
    int          mismatches;

    function new();
      clear();
      reports_seen = 0;
      good_headers = 0;
      mismatches   = 0;
    endfunction

    function void clear();
      mode       = MODE_HEADER;
      at_start   = 1'b1;
      pos        = 4'd0;
      kw_flags   = KW_ALL;
      name_seen  = 1'b0;
      offset     = 32'd0;
      body_start = 32'd0;
      line_start = 32'd0;
      files      = 16'd0;
      body_total = 32'd0;
      errors     = 16'd0;
      end_seen   = 1'b0;
      hash       = FNV_BASIS;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void bump_errors();
      if (errors != 16'hFFFF) errors++;
    endfunction

    function void add_body(logic [31:0] n);
      logic [32:0] s;
      s = {1'b0, body_total} + {1'b0, n};
      body_total = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void match_char(logic [7:0] b);
      int  p;
      logic blank;
      p = int'(pos);
      blank = (b == CHAR_SP) || (b == CHAR_TAB);
      if (p < 7) begin
        if (HDR_WORD[8*(6-p) +: 8] != b) kw_flags[KW_HDR] = 1'b0;
        if (ENDF_WORD[8*(6-p) +: 8] != b) kw_flags[KW_ENDF] = 1'b0;
        if (p >= 3 || ENDF_WORD[8*(6-p) +: 8] != b) kw_flags[KW_END] = 1'b0;
      end else begin
        kw_flags[KW_HDR]  = 1'b0;
        kw_flags[KW_ENDF] = 1'b0;
        kw_flags[KW_END]  = 1'b0;
      end
      if (p < 4) begin
        if (FILE_WORD[8*(3-p) +: 8] != b) kw_flags[KW_FILE] = 1'b0;
      end else if (p == 4) begin
        if (!blank) kw_flags[KW_FILE] = 1'b0;
      end else if (!blank) begin
        name_seen = 1'b1;
      end
      pos = (pos < POS_MAX) ? pos + 4'd1 : POS_MAX;
    endfunction

    function void line_done();
      case (mode)
        MODE_HEADER: begin
          if (kw_flags[KW_HDR] && pos == 4'd7) begin
            mode = MODE_MAIN;
          end else begin
            errors = 16'd1;
            mode   = MODE_BAD;
          end
        end
        MODE_MAIN: begin
          if (kw_flags[KW_END] && pos == 4'd3) begin
            end_seen = 1'b1;
            mode     = MODE_DONE;
          end else if (kw_flags[KW_FILE] && pos >= 4'd4) begin
            if (files != 16'hFFFF) files++;
            if (!name_seen) bump_errors();
            mode = MODE_BODY_WAIT;
          end
        end
        MODE_BODY: begin
          if (kw_flags[KW_ENDF] && pos == 4'd7) begin
            add_body(line_start - body_start);
            mode = MODE_MAIN;
          end
        end
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      tpsv_res_t r;
      hash = (hash ^ {24'd0, b}) * FNV_PRIME;
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (!at_start) line_done();
        at_start = 1'b1;
      end else begin
        if (at_start) begin
          at_start   = 1'b0;
          pos        = 4'd0;
          kw_flags   = KW_ALL;
          name_seen  = 1'b0;
          line_start = offset;
          if (mode == MODE_BODY_WAIT) begin
            body_start = offset;
            mode       = MODE_BODY;
          end
        end
        match_char(b);
      end
      offset++;
      if (!fin) return;
      if (!at_start) line_done();
      if (mode == MODE_HEADER) begin
        errors = 16'd1;
        mode   = MODE_BAD;
      end else if (mode == MODE_BODY_WAIT) begin
        bump_errors();
      end else if (mode == MODE_BODY) begin
        bump_errors();
        add_body(line_start - body_start);
      end
      r.valid_res = (mode != MODE_BAD);
      if (r.valid_res && files == 16'd0) bump_errors();
      r.file_count  = files;
      r.body_bytes  = body_total;
      r.error_count = errors;
      r.end_missing = !end_seen;
      r.hash        = hash;
      if (r.valid_res) good_headers++;
      pending_reports.push_back(r);
      clear();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(tpsv_res_t got);
      tpsv_res_t want;
      if (pending_reports.size() == 0) begin
        $error("report with no package pending");
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      reports_seen++;
      compare_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
      compare_field("file_count", 32'(want.file_count), 32'(got.file_count));
      compare_field("body_bytes", want.body_bytes, got.body_bytes);
      compare_field("error_count", 32'(want.error_count), 32'(got.error_count));
      compare_field("end_missing", 32'(want.end_missing), 32'(got.end_missing));
      compare_field("hash", want.hash, got.hash);
    endfunction
  endclass

endpackage

// ----- sim/tb.sv -----
// Testbench top for text_package_stream_verifier_top: drives well-formed and
// broken packages byte by byte under random idling and checks every report.
// Depends on tpsv_pkg, tpsv_scan_pkg and the RTL.
module tb;
  import tpsv_pkg::*;
  import tpsv_scan_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTES_PER_PHASE = 450;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_HOLD       = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_valid_res;
  logic [15:0] out_file_count;
  logic [31:0] out_body_bytes;
  logic [15:0] out_error_count;
  logic        out_end_missing;
  logic [31:0] out_hash;

  pkg_scan_board scan;
  logic [7:0]    pkg_bytes[$];
  int            phase = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            sent_bytes = 0;
  int            packages_sent = 0;
  int unsigned   cycle_count = 0;

  text_package_stream_verifier_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_in      (in_byte_in),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_valid_res   (out_valid_res),
    .out_file_count  (out_file_count),
    .out_body_bytes  (out_body_bytes),
    .out_error_count (out_error_count),
    .out_end_missing (out_end_missing),
    .out_hash        (out_hash)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_package_stream_verifier_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      scan.check_report({out_valid_res, out_file_count, out_body_bytes, out_error_count,
                         out_end_missing, out_hash});
  end

  initial begin : receiver
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held_once) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic void push_word(logic [55:0] w, int len, int n);
    for (int i = 0; i < n; i++) pkg_bytes.push_back(w[8*(len-1-i) +: 8]);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) pkg_bytes.push_back(8'(s[i]));
  endfunction

  function automatic void push_sep();
    repeat ($urandom_range(1, 3)) pkg_bytes.push_back($urandom_range(1) ? CHAR_CR : CHAR_LF);
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CHAR_SP : CHAR_TAB;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8'h20, 8'h7E));
    if (c == CHAR_CR || c == CHAR_LF) c = c ^ 8'h20;
    return c;
  endfunction

  function automatic void push_text(int maxlen);
    repeat ($urandom_range(1, maxlen)) pkg_bytes.push_back(text_char());
  endfunction

  function automatic void push_file_line();
    push_word(56'(FILE_WORD), 4, 4);
    case ($urandom_range(3))
      0: ;
      1: repeat ($urandom_range(1, 3)) pkg_bytes.push_back(blank_char());
      default: begin
        pkg_bytes.push_back(blank_char());
        push_text(6);
      end
    endcase
  endfunction

  function automatic void push_near_miss();
    case ($urandom_range(4))
      0: push_word(ENDF_WORD, 7, $urandom_range(1, 6));
      1: begin
        push_word(ENDF_WORD, 7, $urandom_range(3, 7));
        pkg_bytes.push_back(text_char());
      end
      2: push_word(56'(FILE_WORD), 4, $urandom_range(1, 3));
      3: begin
        push_word(56'(FILE_WORD), 4, 4);
        pkg_bytes.push_back(text_char());
      end
      default: push_word(ENDF_WORD, 7, 7);
    endcase
  endfunction

  function automatic void make_package();
    int kind;
    int pick;
    pkg_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) pkg_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(3) == 0) push_sep();
    if (kind < 16) begin
      case ($urandom_range(2))
        0: push_word(HDR_WORD, 7, $urandom_range(1, 6));
        1: begin
          push_word(HDR_WORD, 7, $urandom_range(6));
          pkg_bytes.push_back(text_char());
        end
        default: begin
          push_word(HDR_WORD, 7, 7);
          pkg_bytes.push_back(text_char());
        end
      endcase
    end else begin
      push_word(HDR_WORD, 7, 7);
    end
    repeat ($urandom_range(0, 5)) begin
      push_sep();
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_file_line();
        repeat ($urandom_range(0, 3)) begin
          push_sep();
          case ($urandom_range(5))
            0: push_word(ENDF_WORD, 7, 3);
            1: push_file_line();
            2: push_word(HDR_WORD, 7, 7);
            default: push_text(8);
          endcase
        end
        if ($urandom_range(99) < 85) begin
          push_sep();
          push_word(ENDF_WORD, 7, 7);
        end
      end else if (pick < 65) begin
        push_text(20);
      end else begin
        push_near_miss();
      end
    end
    if ($urandom_range(99) < 80) begin
      push_sep();
      push_word(ENDF_WORD, 7, 3);
      if ($urandom_range(3) == 0) begin
        push_sep();
        push_file_line();
      end
    end
    if ($urandom_range(1)) push_sep();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_byte_in   <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (in_stall);
    scan.take_byte(b, fin);
    sent_bytes++;
  endtask

  task automatic send_package();
    int n;
    n = pkg_bytes.size();
    for (int i = 0; i < n; i++) send_byte(pkg_bytes[i], i == n - 1);
    packages_sent++;
  endtask

  task automatic run_directed();
    pkg_bytes = '{8'h00};
    send_package();
    pkg_bytes = '{8'hFF};
    send_package();
    pkg_bytes.delete();
    push_str("\015\n\n");
    push_word(HDR_WORD, 7, 7);
    push_str("\nEND");
    send_package();
    pkg_bytes.delete();
    push_word(HDR_WORD, 7, 7);
    push_str("\nFILE\nx\015\nENDFILE\nEND\n");
    send_package();
    pkg_bytes.delete();
    push_word(HDR_WORD, 7, 7);
    push_str("\nFILE a\nEND\nFILE q\nENDFILE\nFILE \t\n\tz\nENDFILE\nEND");
    send_package();
    pkg_bytes.delete();
    push_word(HDR_WORD, 7, 7);
    push_str("\nFILE\t \nab\ncd");
    send_package();
    pkg_bytes.delete();
    push_word(HDR_WORD, 7, 7);
    push_str("\nFILE b");
    send_package();
    pkg_bytes.delete();
    push_word(HDR_WORD, 7, 6);
    push_str("2\nEND\n");
    send_package();
    pkg_bytes.delete();
    push_word(HDR_WORD, 7, 7);
    push_str("\nEND\nFILE c\n");
    send_package();
  endtask

  initial begin : stimulus
    scan = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      phase = ph;
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 28 : 0;
      if (ph == 0) run_directed();
      while (sent_bytes < (ph + 1) * BYTES_PER_PHASE) begin
        make_package();
        send_package();
      end
      in_valid <= 1'b0;
      do @(posedge clk); while (scan.pending() != 0);
    end
    repeat (4) @(posedge clk);
    $display("Sent %0d packages (%0d bytes); %0d reports checked, %0d with a valid header.",
             packages_sent, sent_bytes, scan.reports_seen, scan.good_headers);
    if (scan.mismatches == 0 && scan.pending() == 0) begin
      $display("text_package_stream_verifier_top: match");
    end else begin
      $display("text_package_stream_verifier_top: mismatch");
    end
    $finish;
  end

endmodule
